// ----- hdl/tpi_pkg.sv -----
`default_nettype none
package tpi_pkg;

  // sizes
  localparam int STACK_DEPTH     = 64;
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int CNT_W           = $clog2(STACK_DEPTH + 1);
  localparam int TAB_AW          = $clog2(SINE_TABLE_SIZE + 1);
  localparam int NUM_REGS        = 5;
  localparam int ADDR_W          = $clog2(NUM_REGS * 4);

  // register reset values
  localparam logic [31:0] START_X_RST       = 32'd128000;
  localparam logic [31:0] START_Y_RST       = 32'd64000;
  localparam logic [15:0] START_HEADING_RST = 16'd49152;
  localparam logic [15:0] STEP_LENGTH_RST   = 16'd2560;
  localparam logic [15:0] TURN_STEP_RST     = 16'd16384;

  // register indexes
  localparam logic [ADDR_W-3:0] REG_START_X       = (ADDR_W-2)'(0);
  localparam logic [ADDR_W-3:0] REG_START_Y       = (ADDR_W-2)'(1);
  localparam logic [ADDR_W-3:0] REG_START_HEADING = (ADDR_W-2)'(2);
  localparam logic [ADDR_W-3:0] REG_STEP_LENGTH   = (ADDR_W-2)'(3);
  localparam logic [ADDR_W-3:0] REG_TURN_STEP     = (ADDR_W-2)'(4);

  // commands
  localparam logic CMD_SYMBOL  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // turtle symbols (ascii)
  localparam logic [7:0] SYM_FWD_DRAW  = 8'h46; // F
  localparam logic [7:0] SYM_FWD_MOVE  = 8'h66; // f
  localparam logic [7:0] SYM_HALF_DRAW = 8'h48; // H
  localparam logic [7:0] SYM_HALF_MOVE = 8'h68; // h
  localparam logic [7:0] SYM_TURN_POS  = 8'h2B; // +
  localparam logic [7:0] SYM_TURN_NEG  = 8'h2D; // -
  localparam logic [7:0] SYM_REVERSE   = 8'h7C; // |
  localparam logic [7:0] SYM_PUSH      = 8'h5B; // [
  localparam logic [7:0] SYM_POP       = 8'h5D; // ]

  // fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FULL  = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;
  localparam logic [1:0] FAULT_SAT   = 2'd3;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [15:0] HALF_TURN    = 16'h8000;

  // turtle state held by the current registers and by each stack slot
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        heading;
  } turtle_state_t;

  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2
  } stack_op_t;

  // sine or cosine as sign and q1.15 magnitude
  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } trig_t;

  typedef logic [15:0] sin_tab_t [SINE_TABLE_SIZE + 1];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // quarter-wave table, taylor series to x^13 in q30, rounded to q1.15
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t        tab;
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          r;
    for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_SIZE;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TAYLOR_DIV[n-1];
        if (n[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 64'sd32768) begin
        r = 64'sd32768;
      end
      tab[k] = 16'(r);
    end
    return tab;
  endfunction

  // table index for a phase, mirrored in odd quadrants
  function automatic logic [TAB_AW-1:0] tab_index(logic [15:0] p);
    logic [TAB_AW+13:0] prod;
    logic [TAB_AW-1:0]  i;
    prod = (TAB_AW + 14)'(p[13:0]) * (TAB_AW + 14)'(SINE_TABLE_SIZE);
    i    = prod[TAB_AW+13:14];
    return p[14] ? TAB_AW'(SINE_TABLE_SIZE) - i : i;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tpi_stack_cell.sv -----
`default_nettype none
module tpi_stack_cell
  import tpi_pkg::*;
(
  input  wire logic          clk,
  input  wire stack_op_t     op,
  input  wire turtle_state_t from_above,
  input  wire turtle_state_t from_below,
  output turtle_state_t      q
);

  // push shifts down from the slot above, pop shifts up from the slot below
  always_ff @(posedge clk) begin
    case (op)
      STK_PUSH: q <= from_above;
      STK_POP:  q <= from_below;
      default:  q <= q;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/tpi_trig_rom.sv -----
`default_nettype none
module tpi_trig_rom
  import tpi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [15:0] heading,
  output trig_t            sin_val,
  output trig_t            cos_val
);

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  logic [15:0]       cos_phase;
  logic [TAB_AW-1:0] sin_idx;
  logic [TAB_AW-1:0] cos_idx;

  assign cos_phase = heading + QUARTER_TURN;
  assign sin_idx   = tab_index(heading);
  assign cos_idx   = tab_index(cos_phase);

  // two registered read ports, quadrants 2 and 3 are negative
  always_ff @(posedge clk) begin
    sin_val.mag <= SIN_TAB[sin_idx];
    sin_val.neg <= heading[15];
    cos_val.mag <= SIN_TAB[cos_idx];
    cos_val.neg <= cos_phase[15];
  end

endmodule
`default_nettype wire

// ----- hdl/tpi_advance.sv -----
`default_nettype none
module tpi_advance
  import tpi_pkg::*;
(
  input  wire logic signed [31:0] pos,
  input  wire trig_t              factor,
  input  wire logic [15:0]        step_length,
  input  wire logic               half,
  output logic signed [31:0]      pos_next,
  output logic                    sat
);

  logic [31:0]        prod;
  logic [32:0]        rounded;
  logic [17:0]        delta;
  logic signed [33:0] pos_ext;
  logic signed [33:0] delta_ext;
  logic signed [33:0] sum;

  // magnitude product, rounded half away from zero by the sign split
  assign prod    = 32'(factor.mag) * 32'(step_length);
  assign rounded = 33'(prod) + (half ? 33'h8000 : 33'h4000);
  assign delta   = half ? {1'b0, rounded[32:16]} : rounded[32:15];

  assign pos_ext   = 34'(pos);
  assign delta_ext = factor.neg ? -$signed(34'(delta)) : $signed(34'(delta));
  assign sum       = pos_ext + delta_ext;

  // saturate to the 32 bit signed range
  assign sat = (sum[33:31] != 3'b000) && (sum[33:31] != 3'b111);

  always_comb begin
    if (!sat) begin
      pos_next = sum[31:0];
    end else if (sum[33]) begin
      pos_next = 32'sh8000_0000;
    end else begin
      pos_next = 32'sh7FFF_FFFF;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/turtle_path_interpreter.sv -----
`default_nettype none
// Turtle path interpreter: takes one expanded L-system symbol per transaction on the
// s_ side and returns the new turtle position and heading on the m_ side.
// s_tuser carries the command (0 interpret, 1 restart), s_tdata the ascii symbol.
// F and H step by the full or half length and draw, f and h step without drawing,
// + and - turn, | reverses, [ and ] push and pop the state on a 64 entry stack.
// Unknown symbols are dropped and give no result transaction.
// The result is offered on m_ the cycle after acceptance.
// Throughput is one symbol per cycle while m_ does not stall; the figure is set by
// the position update loop, which reads the registered sine/cosine of the current
// heading, multiplies by the step length and adds to the position. The sine table
// is read at the next heading, and the stack is a row of shifting slots whose top
// is always at hand.
// Configuration registers sit on the apb port at byte offsets 0, 4, 8, 12, 16 and
// should be written only while the block is idle; a restart loads the new start.
// Reset loads the default registers and start state, empties the stack and clears
// the output. When m_tready is low a waiting result holds and s_tready drops.
module turtle_path_interpreter
  import tpi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // apb configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // symbol stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] symbol
  input  wire logic [0:0]        s_tuser,   // [0] command
  // result stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [79:0]            m_tdata,   // [31:0] pos_x, [63:32] pos_y, [79:64] heading
  output logic [2:0]             m_tuser    // [0] draw, [2:1] fault
);

  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [15:0] start_heading;
  logic [15:0] step_length;
  logic [15:0] turn_step;

  turtle_state_t cur;
  turtle_state_t cur_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  stack_op_t        op;
  turtle_state_t    slots [STACK_DEPTH];

  logic        in_fire;
  logic        emit;
  logic        draw_res;
  logic [1:0]  fault_res;
  logic        half;
  logic        cfg_wr;
  logic [15:0] rom_heading;

  trig_t              sin_val;
  trig_t              cos_val;
  logic signed [31:0] adv_x;
  logic signed [31:0] adv_y;
  logic               sat_x;
  logic               sat_y;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x       <= START_X_RST;
      start_y       <= START_Y_RST;
      start_heading <= START_HEADING_RST;
      step_length   <= STEP_LENGTH_RST;
      turn_step     <= TURN_STEP_RST;
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_START_X:       start_x       <= pwdata;
        REG_START_Y:       start_y       <= pwdata;
        REG_START_HEADING: start_heading <= pwdata[15:0];
        REG_STEP_LENGTH:   step_length   <= pwdata[15:0];
        REG_TURN_STEP:     turn_step     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_START_X:       prdata = start_x;
      REG_START_Y:       prdata = start_y;
      REG_START_HEADING: prdata = 32'(start_heading);
      REG_STEP_LENGTH:   prdata = 32'(step_length);
      REG_TURN_STEP:     prdata = 32'(turn_step);
      default:           prdata = 32'd0;
    endcase
  end

  // sine and cosine of the current heading, read from the table at the next heading
  assign rom_heading = rst ? START_HEADING_RST : cur_next.heading;

  tpi_trig_rom u_trig (
    .clk     (clk),
    .heading (rom_heading),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  assign half = (s_tdata == SYM_HALF_DRAW) || (s_tdata == SYM_HALF_MOVE);

  tpi_advance u_adv_x (
    .pos         (cur.x),
    .factor      (cos_val),
    .step_length (step_length),
    .half        (half),
    .pos_next    (adv_x),
    .sat         (sat_x)
  );

  // positive sine moves y down the screen
  tpi_advance u_adv_y (
    .pos         (cur.y),
    .factor      (sin_val),
    .step_length (step_length),
    .half        (half),
    .pos_next    (adv_y),
    .sat         (sat_y)
  );

  // handshake: output register parts the two sides
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // symbol decode and next state
  always_comb begin
    cur_next   = cur;
    count_next = count;
    op         = STK_HOLD;
    emit       = 1'b0;
    draw_res   = 1'b0;
    fault_res  = FAULT_NONE;
    if (in_fire) begin
      if (s_tuser[0] == CMD_RESTART) begin
        cur_next.x       = start_x;
        cur_next.y       = start_y;
        cur_next.heading = start_heading;
        count_next       = '0;
        emit             = 1'b1;
      end else begin
        case (s_tdata)
          SYM_FWD_DRAW, SYM_FWD_MOVE, SYM_HALF_DRAW, SYM_HALF_MOVE: begin
            cur_next.x = adv_x;
            cur_next.y = adv_y;
            fault_res  = (sat_x || sat_y) ? FAULT_SAT : FAULT_NONE;
            draw_res   = s_tdata inside {SYM_FWD_DRAW, SYM_HALF_DRAW};
            emit       = 1'b1;
          end
          SYM_TURN_POS: begin
            cur_next.heading = cur.heading - turn_step;
            emit             = 1'b1;
          end
          SYM_TURN_NEG: begin
            cur_next.heading = cur.heading + turn_step;
            emit             = 1'b1;
          end
          SYM_REVERSE: begin
            cur_next.heading = cur.heading + HALF_TURN;
            emit             = 1'b1;
          end
          SYM_PUSH: begin
            if (count == CNT_W'(STACK_DEPTH)) begin
              fault_res = FAULT_FULL;
            end else begin
              op         = STK_PUSH;
              count_next = count + 1'b1;
            end
            emit = 1'b1;
          end
          SYM_POP: begin
            if (count == '0) begin
              fault_res = FAULT_EMPTY;
            end else begin
              op         = STK_POP;
              count_next = count - 1'b1;
              cur_next   = slots[0];
            end
            emit = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // row of stack slots, top at index zero
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_stack
    turtle_state_t above;
    turtle_state_t below;
    if (g == 0) begin : g_top
      assign above = cur;
    end else begin : g_mid
      assign above = slots[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bottom
      assign below = slots[g];
    end else begin : g_inner
      assign below = slots[g+1];
    end
    tpi_stack_cell u_slot (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .q          (slots[g])
    );
  end

  // turtle state and stack fill
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.x       <= START_X_RST;
      cur.y       <= START_Y_RST;
      cur.heading <= START_HEADING_RST;
      count       <= '0;
    end else begin
      cur   <= cur_next;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {cur_next.heading, cur_next.y, cur_next.x};
      m_tuser <= {fault_res, draw_res};
    end
  end

  // checks
  a_trig_sign: assert property (@(posedge clk) disable iff (rst)
    sin_val.neg == cur.heading[15])
    else $error("sine sign out of step with heading");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser[0] == CMD_SYMBOL && s_tdata == SYM_PUSH &&
     count != CNT_W'(STACK_DEPTH)) |=> count == $past(count) + 1'b1)
    else $error("push did not grow the stack");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser[0] == CMD_SYMBOL && s_tdata == SYM_POP && count == '0)
    |=> m_tvalid && m_tuser[2:1] == FAULT_EMPTY)
    else $error("pop on empty stack not flagged");

  a_drop_unknown: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !emit) |=> !m_tvalid)
    else $error("dropped symbol produced a result");

endmodule
`default_nettype wire
